// ----- design/cubic_congestion_window_curve_top_assert.svh -----
// Assertion macros for the cubic window curve block.
`ifndef CUBIC_CONGESTION_WINDOW_CURVE_TOP_ASSERT_SVH
`define CUBIC_CONGESTION_WINDOW_CURVE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CCWC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CCWC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ccwc_pkg.sv -----
`timescale 1ns / 1ps

package ccwc_pkg;

  // field widths
  localparam int WINDOW_BITS = 20;
  localparam int TIME_BITS   = 32;
  localparam int PLATEAU_W   = 17;
  localparam int WIN_OUT_W   = 21;

  // plateau: K = floor(cbrt(W * 750000000)), three bits of radicand per root bit
  localparam int                 KSCALE_W    = 30;
  localparam logic [KSCALE_W-1:0] K_SCALE    = 30'd750000000;
  localparam int PROD_W      = WINDOW_BITS + KSCALE_W;
  localparam int ROOT_STEPS  = (PROD_W + 2) / 3;
  localparam int ROOT_W      = ROOT_STEPS;
  localparam int ROOT_SQ_W   = 2 * ROOT_W;
  localparam int TRIAL_W     = 2 * ROOT_W + 4;
  localparam int ROOT_CMP_W  = (PROD_W > TRIAL_W) ? PROD_W : TRIAL_W;
  localparam int ROOT_TOP_SH = 3 * (ROOT_STEPS - 1);

  // distance from plateau
  localparam int DIFF_W = (TIME_BITS > ROOT_W) ? TIME_BITS : ROOT_W;
  localparam int MAG_W  = 17;
  localparam logic [MAG_W-1:0] DIST_CAP = 17'd100000;

  // cubic term: (mag^3 + 1.25e9) / 2.5e9 = ((x >> 8) / 5^10)
  localparam int SQ_W    = 34;
  localparam int CUBE_W  = 50;
  localparam logic [CUBE_W-1:0] ROUND_HALF = 50'd1250000000;
  localparam int Y_SHIFT  = 8;
  localparam int Y_W      = CUBE_W - Y_SHIFT;
  localparam int YH_SHIFT = 10;
  localparam int YH_W     = Y_W - YH_SHIFT;
  localparam int RECIP_W  = 19;
  // floor(2^42 / 5^10)
  localparam logic [RECIP_W-1:0] RECIP = 19'd450359;
  localparam int RECIP_SHIFT = 32;
  localparam int QPROD_W     = YH_W + RECIP_W;
  localparam int TERM_W      = 19;
  localparam int DIV_W       = 24;
  localparam logic [DIV_W-1:0] DIV_ODD = 24'd9765625;
  localparam int QD_W        = TERM_W + DIV_W;
  localparam logic [TERM_W-1:0] TERM_MAX = 19'd400000;

  // window sum
  localparam int WSUM_A = (WINDOW_BITS > TERM_W) ? WINDOW_BITS : TERM_W;
  localparam int WSUM_W = ((WSUM_A > WIN_OUT_W) ? WSUM_A : WIN_OUT_W) + 1;
  localparam int PL_EXT_W = (ROOT_W > PLATEAU_W) ? ROOT_W : PLATEAU_W;

  typedef struct packed {
    logic [WINDOW_BITS-1:0] window_at_loss;
    logic [TIME_BITS-1:0]   elapsed_ms;
  } ccwc_in_t;

  typedef struct packed {
    logic [PLATEAU_W-1:0] plateau_ms;
    logic [WIN_OUT_W-1:0] target_window;
  } ccwc_out_t;

  typedef struct packed {
    logic [WINDOW_BITS-1:0] w;
    logic [TIME_BITS-1:0]   t;
  } ccwc_tag_t;

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    ccwc_tag_t         tag;
  } ccwc_root_in_t;

  typedef struct packed {
    logic [ROOT_W-1:0] k;
    ccwc_tag_t         tag;
  } ccwc_root_out_t;

  typedef struct packed {
    logic [TERM_W-1:0]      term;
    logic                   behind;
    logic [ROOT_W-1:0]      k;
    logic [WINDOW_BITS-1:0] w;
  } ccwc_term_t;

endpackage

// ----- design/ccwc_cbrt.sv -----
`timescale 1ns / 1ps

// Pipelined digit-by-digit cube root, one root bit per stage.
module ccwc_cbrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ccwc_pkg::ccwc_root_in_t    in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ccwc_pkg::ccwc_root_out_t   out_data
);
  import ccwc_pkg::*;

  typedef struct packed {
    logic [PROD_W-1:0]    rem;
    logic [ROOT_W-1:0]    root;
    logic [ROOT_SQ_W-1:0] root_sq;
    ccwc_tag_t            tag;
  } ccwc_rstage_t;

  logic         v_r    [ROOT_STEPS];
  logic         v_in   [ROOT_STEPS];
  logic         rdy    [ROOT_STEPS];
  ccwc_rstage_t st_r   [ROOT_STEPS];
  ccwc_rstage_t st_in  [ROOT_STEPS];
  ccwc_rstage_t st_nxt [ROOT_STEPS];

  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
    localparam int SH = ROOT_TOP_SH - 3 * i;
    localparam logic [PROD_W-1:0] LO_MASK = ~({PROD_W{1'b1}} << SH);

    logic [ROOT_CMP_W-1:0] hi;
    logic [ROOT_CMP_W-1:0] trial;
    logic [ROOT_CMP_W-1:0] diff;
    logic                  take;

    if (i == 0) begin : g_first
      assign v_in[i]  = in_valid;
      assign st_in[i] = '{rem: in_data.rem, root: '0, root_sq: '0, tag: in_data.tag};
    end else begin : g_chain
      assign v_in[i]  = v_r[i-1];
      assign st_in[i] = st_r[i-1];
    end

    if (i == ROOT_STEPS - 1) begin : g_last
      assign rdy[i] = !v_r[i] || out_ready;
    end else begin : g_mid
      assign rdy[i] = !v_r[i] || rdy[i+1];
    end

    // trial = 12*r^2 + 6*r + 1 for the doubled root
    always_comb begin
      hi    = ROOT_CMP_W'(st_in[i].rem >> SH);
      trial = ROOT_CMP_W'({st_in[i].root_sq, 3'b000}) + ROOT_CMP_W'({st_in[i].root_sq, 2'b00})
            + ROOT_CMP_W'({st_in[i].root, 2'b00}) + ROOT_CMP_W'({st_in[i].root, 1'b0})
            + ROOT_CMP_W'(1);
      take  = hi >= trial;
      diff  = hi - trial;
      st_nxt[i].tag  = st_in[i].tag;
      st_nxt[i].rem  = take ? (PROD_W'(diff << SH) | (st_in[i].rem & LO_MASK))
                            : st_in[i].rem;
      st_nxt[i].root = {st_in[i].root[ROOT_W-2:0], take};
      // (2r+b)^2 = 4r^2 + b*(4r+1)
      st_nxt[i].root_sq = {st_in[i].root_sq[ROOT_SQ_W-3:0], 2'b00}
                        + (ROOT_SQ_W'({st_in[i].root, 2'b00}) & {ROOT_SQ_W{take}})
                        + ROOT_SQ_W'(take);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[ROOT_STEPS-1];
  assign out_data  = '{k: st_r[ROOT_STEPS-1].root, tag: st_r[ROOT_STEPS-1].tag};

endmodule

// ----- design/ccwc_term.sv -----
`timescale 1ns / 1ps

// Distance to plateau, cube, and rounded division by 2.5e9.
module ccwc_term (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ccwc_pkg::ccwc_root_out_t   in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ccwc_pkg::ccwc_term_t       out_data
);
  import ccwc_pkg::*;

  localparam int NSTG = 7;

  typedef struct packed {
    logic                   behind;
    logic [ROOT_W-1:0]      k;
    logic [WINDOW_BITS-1:0] w;
  } ccwc_carry_t;

  typedef struct packed {
    ccwc_carry_t      c;
    logic [MAG_W-1:0] mag;
  } ccwc_s0_t;

  typedef struct packed {
    ccwc_carry_t      c;
    logic [MAG_W-1:0] mag;
    logic [SQ_W-1:0]  sq;
  } ccwc_s1_t;

  typedef struct packed {
    ccwc_carry_t       c;
    logic [CUBE_W-1:0] cube;
  } ccwc_s2_t;

  typedef struct packed {
    ccwc_carry_t    c;
    logic [Y_W-1:0] y;
  } ccwc_s3_t;

  typedef struct packed {
    ccwc_carry_t       c;
    logic [Y_W-1:0]    y;
    logic [TERM_W-1:0] q0;
  } ccwc_s4_t;

  typedef struct packed {
    ccwc_carry_t       c;
    logic [Y_W-1:0]    y;
    logic [TERM_W-1:0] q0;
    logic [QD_W-1:0]   qd;
  } ccwc_s5_t;

  logic v_r [NSTG];
  logic rdy [NSTG];

  ccwc_s0_t   s0_r, s0_nxt;
  ccwc_s1_t   s1_r, s1_nxt;
  ccwc_s2_t   s2_r, s2_nxt;
  ccwc_s3_t   s3_r, s3_nxt;
  ccwc_s4_t   s4_r, s4_nxt;
  ccwc_s5_t   s5_r, s5_nxt;
  ccwc_term_t s6_r, s6_nxt;

  logic [DIFF_W-1:0] tt, kk, gap;
  logic [Y_W-1:0]    rem;

  for (genvar i = 0; i < NSTG; i++) begin : g_rdy
    if (i == NSTG - 1) begin : g_last
      assign rdy[i] = !v_r[i] || out_ready;
    end else begin : g_mid
      assign rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    // signed distance t - K, magnitude capped
    tt = DIFF_W'(in_data.tag.t);
    kk = DIFF_W'(in_data.k);
    s0_nxt.c.behind = tt < kk;
    s0_nxt.c.k      = in_data.k;
    s0_nxt.c.w      = in_data.tag.w;
    gap             = s0_nxt.c.behind ? (kk - tt) : (tt - kk);
    s0_nxt.mag      = (gap > DIFF_W'(DIST_CAP)) ? DIST_CAP : MAG_W'(gap);

    s1_nxt.c   = s0_r.c;
    s1_nxt.mag = s0_r.mag;
    s1_nxt.sq  = SQ_W'(s0_r.mag) * SQ_W'(s0_r.mag);

    s2_nxt.c    = s1_r.c;
    s2_nxt.cube = CUBE_W'(s1_r.sq) * CUBE_W'(s1_r.mag);

    // 2.5e9 = 2^8 * 5^10
    s3_nxt.c = s2_r.c;
    s3_nxt.y = Y_W'((s2_r.cube + ROUND_HALF) >> Y_SHIFT);

    // estimate low by at most two
    s4_nxt.c  = s3_r.c;
    s4_nxt.y  = s3_r.y;
    s4_nxt.q0 = TERM_W'((QPROD_W'(s3_r.y[Y_W-1:YH_SHIFT]) * QPROD_W'(RECIP)) >> RECIP_SHIFT);

    s5_nxt.c  = s4_r.c;
    s5_nxt.y  = s4_r.y;
    s5_nxt.q0 = s4_r.q0;
    s5_nxt.qd = QD_W'(s4_r.q0) * QD_W'(DIV_ODD);

    rem           = s5_r.y - Y_W'(s5_r.qd);
    s6_nxt.behind = s5_r.c.behind;
    s6_nxt.k      = s5_r.c.k;
    s6_nxt.w      = s5_r.c.w;
    if (rem >= Y_W'({DIV_ODD, 1'b0})) begin
      s6_nxt.term = s5_r.q0 + TERM_W'(2);
    end else if (rem >= Y_W'(DIV_ODD)) begin
      s6_nxt.term = s5_r.q0 + TERM_W'(1);
    end else begin
      s6_nxt.term = s5_r.q0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) s0_r <= s0_nxt;
    if (rdy[1]) s1_r <= s1_nxt;
    if (rdy[2]) s2_r <= s2_nxt;
    if (rdy[3]) s3_r <= s3_nxt;
    if (rdy[4]) s4_r <= s4_nxt;
    if (rdy[5]) s5_r <= s5_nxt;
    if (rdy[6]) s6_r <= s6_nxt;
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = s6_r;

endmodule

// ----- design/cubic_congestion_window_curve_top.sv -----
`timescale 1ns / 1ps
// Cubic congestion window curve.
// Input channel (in_valid/in_ready/in_data): one word per evaluation, carrying the
// window at the last loss and the elapsed time in ms. Output channel
// (out_valid/out_ready/out_data): one word per input word, in order, carrying the
// plateau time K and the target window W + sign(t-K)*round(min(|t-K|,1e5)^3/2.5e9),
// clamped at zero.
// Pipeline: 26 register stages, in order: 1 multiply stage, one cube root stage per
// root bit - 17 at the default window width - 7 term stages and the output
// register.
// Throughput: one word per cycle; every stage is a single register slice with
// its own valid bit, so a new word enters each cycle the pipeline moves.
// Stall: when out_ready is low, the full stages hold and bubbles behind them
// still fill, so in_ready drops only once every stage is occupied.
// Reset (rst_n low, synchronous) clears all valid bits; the data registers are not
// reset, and in_ready is high as soon as reset is released.
`include "cubic_congestion_window_curve_top_assert.svh"

module cubic_congestion_window_curve_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ccwc_pkg::ccwc_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ccwc_pkg::ccwc_out_t  out_data
);
  import ccwc_pkg::*;

  // stage P: radicand W * 750000000
  logic          p_v_r;
  ccwc_root_in_t p_data_r, p_data_nxt;
  logic          p_rdy;

  logic           root_in_ready;
  logic           root_valid;
  ccwc_root_out_t root_q;
  logic           root_ready;

  logic       term_valid;
  ccwc_term_t term_q;
  logic       term_ready;

  // output register
  logic      out_valid_r;
  ccwc_out_t out_data_r, out_data_nxt;
  logic      out_rdy;

  logic [WSUM_W-1:0]   wext, text, wsum;
  logic [PL_EXT_W-1:0] kext;

  assign p_rdy    = !p_v_r || root_in_ready;
  assign in_ready = p_rdy;

  always_comb begin
    p_data_nxt.rem   = PROD_W'(in_data.window_at_loss) * PROD_W'(K_SCALE);
    p_data_nxt.tag.w = in_data.window_at_loss;
    p_data_nxt.tag.t = in_data.elapsed_ms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (p_rdy) begin
      p_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_rdy) begin
      p_data_r <= p_data_nxt;
    end
  end

  ccwc_cbrt u_cbrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_v_r),
    .in_ready  (root_in_ready),
    .in_data   (p_data_r),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .out_data  (root_q)
  );

  ccwc_term u_term (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (root_valid),
    .in_ready  (root_ready),
    .in_data   (root_q),
    .out_valid (term_valid),
    .out_ready (term_ready),
    .out_data  (term_q)
  );

  // final stage: apply the signed term to W, clamp at zero
  assign out_rdy    = !out_valid_r || out_ready;
  assign term_ready = out_rdy;

  always_comb begin
    wext = WSUM_W'(term_q.w);
    text = WSUM_W'(term_q.term);
    kext = PL_EXT_W'(term_q.k);
    if (term_q.behind) begin
      wsum = (text >= wext) ? '0 : (wext - text);
    end else begin
      wsum = wext + text;
    end
    out_data_nxt.plateau_ms    = kext[PLATEAU_W-1:0];
    out_data_nxt.target_window = wsum[WIN_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= term_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // reciprocal division plus correction never exceeds the capped cube term
  `CCWC_ASSERT_IMP(a_term_range, clk, rst_n, term_valid, term_q.term <= TERM_MAX, "cubic term above cap")
  // K is zero exactly when the loss window is zero
  `CCWC_ASSERT_IMP(a_root_zero, clk, rst_n, root_valid, (root_q.k == '0) == (root_q.tag.w == '0), "plateau root inconsistent with window")
  // a blocked product stage keeps its word
  `CCWC_ASSERT_NXT(a_prod_hold, clk, rst_n, p_v_r && !root_in_ready, p_v_r && $stable(p_data_r), "product stage lost a word")

endmodule
